// ===== rtl/lgbr_pkg.sv =====
// lgbr_pkg: shared constants, codes and controller/datapath command types
// for the lagrange-gauss basis reduction block. no dependencies.
`timescale 1ns / 1ps
package lgbr_pkg;

    localparam int DEF_MAX_DIM        = 8;
    localparam int DEF_COMPONENT_BITS = 24;

    localparam int DIM_W    = 4;     // width of the dimension register
    localparam int IDX_IN_W = 3;     // width of the component index fields
    localparam int ACC_W    = 66;    // dot product accumulators and norms
    localparam int DIV_W    = 64;    // rounding divider width
    localparam int DIVC_W   = $clog2(DIV_W);

    // magnitude limit on the dot product accumulators
    localparam logic signed [ACC_W-1:0] BIG_LIMIT = {{(ACC_W-63){1'b0}}, 1'b1, 62'd0};

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] SEL_NN  = 2'd0;   // b0.b0 and b1.b1
    localparam logic [1:0] SEL_D   = 2'd1;   // b0.b1
    localparam logic [1:0] SEL_VV  = 2'd2;   // b0.b0 only
    localparam logic [1:0] SEL_UPD = 2'd3;   // b1 + q*b0

    typedef struct packed {
        logic       wr_en;
        logic       copy_en;
        logic       rd_sel;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_clr;
        logic       ovf_clr;
        logic       order;
        logic       div_init;
        logic       div_step;
        logic       upd_commit;
        logic       vv_latch;
        logic       toggle;
        logic       out_load;
        logic       out_zero;
    } cmd_t;

    typedef struct packed {
        logic ovf;
        logic qbig;
        logic n0_zero;
        logic vv_lt;
    } status_t;

endpackage

// ===== rtl/lgbr_ram.sv =====
// lgbr_ram: generic single write port, single read port ram with registered read.
// no dependencies.
`timescale 1ns / 1ps
module lgbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lgbr_datapath.sv =====
// lgbr_datapath: basis store, working vectors, dot product accumulators,
// rounding divider and update unit. depends on lgbr_pkg and lgbr_ram.
`timescale 1ns / 1ps
module lgbr_datapath
    import lgbr_pkg::*;
#(
    parameter int MAX_DIM        = DEF_MAX_DIM,
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
    parameter int IW             = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cmd_t                             cmd,
    input  logic [IW-1:0]                    cmd_idx,
    output status_t                          stat,
    input  logic                             s_vector_select,
    input  logic [IDX_IN_W-1:0]              s_component_index,
    input  logic signed [COMPONENT_BITS-1:0] s_component_value,
    output logic signed [COMPONENT_BITS-1:0] m_out_value
);

    localparam int CB   = COMPONENT_BITS;
    localparam int RA_W = $clog2(2 * MAX_DIM);
    localparam int QW   = CB + 2;
    localparam int UW   = CB + QW;
    localparam int VW   = 2 * CB + 3;
    localparam logic signed [VW-1:0] C_MAX = (VW'(1) <<< (CB - 1)) - VW'(1);
    localparam logic signed [VW-1:0] C_MIN = -(VW'(1) <<< (CB - 1));

    // basis store
    logic [IW-1:0]   wr_idx;
    logic [RA_W-1:0] ram_waddr;
    logic [RA_W-1:0] ram_raddr;
    logic [CB-1:0]   ram_rdata;

    assign wr_idx    = IW'(s_component_index);
    assign ram_waddr = s_vector_select ? RA_W'(MAX_DIM) + RA_W'(wr_idx) : RA_W'(wr_idx);
    assign ram_raddr = cmd.rd_sel ? RA_W'(MAX_DIM) + RA_W'(cmd_idx) : RA_W'(cmd_idx);

    lgbr_ram #(
        .WIDTH(CB),
        .DEPTH(2 * MAX_DIM)
    ) u_store (
        .aclk (aclk),
        .we   (cmd.wr_en),
        .waddr(ram_waddr),
        .wdata(s_component_value),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // working vectors, sw_reg swaps the logical roles
    logic signed [CB-1:0] vec0_reg [MAX_DIM];
    logic signed [CB-1:0] vec1_reg [MAX_DIM];
    logic                 sw_reg;
    logic signed [CB-1:0] w0, w1;

    assign w0 = sw_reg ? vec1_reg[cmd_idx] : vec0_reg[cmd_idx];
    assign w1 = sw_reg ? vec0_reg[cmd_idx] : vec1_reg[cmd_idx];

    logic            copy_vld_reg;
    logic            copy_sel_reg;
    logic [IW-1:0]   copy_idx_reg;

    // accumulate pipeline
    logic                     p_vld_reg;
    logic [1:0]               p_sel_reg;
    logic signed [2*CB-1:0]   prod_a_reg, prod_b_reg;
    logic signed [ACC_W-1:0]  acc_a_reg, acc_b_reg, acc_a_next, acc_b_next;
    logic signed [ACC_W-1:0]  n0_reg, n1_reg;
    logic                     ovf_reg;
    logic                     acc_a_ovf, acc_b_ovf;

    assign acc_a_next = acc_a_reg + ACC_W'(prod_a_reg);
    assign acc_b_next = acc_b_reg + ACC_W'(prod_b_reg);
    assign acc_a_ovf  = (acc_a_next > BIG_LIMIT) || (acc_a_next < -BIG_LIMIT);
    assign acc_b_ovf  = (p_sel_reg == SEL_NN) &&
                        ((acc_b_next > BIG_LIMIT) || (acc_b_next < -BIG_LIMIT));

    // rounding divider
    logic [DIV_W:0]   rem_reg, rem_sh;
    logic [DIV_W-1:0] quo_reg, den_reg, d_mag;
    logic             d_pos_reg;
    logic signed [QW-1:0] q_val, q_mag;

    assign d_mag  = DIV_W'((acc_a_reg < 0) ? -acc_a_reg : acc_a_reg);
    assign rem_sh = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign q_mag  = QW'(quo_reg);
    assign q_val  = d_pos_reg ? -q_mag : q_mag;

    // update pipeline
    logic                 upd_vld_reg;
    logic [IW-1:0]        upd_idx_reg;
    logic signed [CB-1:0] upd_w1_reg;
    logic signed [UW-1:0] upd_p_reg;
    logic signed [VW-1:0] v_sum;
    logic                 v_bad;

    assign v_sum = VW'(upd_w1_reg) + VW'(upd_p_reg);
    assign v_bad = (v_sum > C_MAX) || (v_sum < C_MIN);

    assign stat.ovf     = ovf_reg;
    assign stat.qbig    = quo_reg > (DIV_W'(1) << CB);
    assign stat.n0_zero = (n0_reg == '0);
    assign stat.vv_lt   = acc_a_reg < n1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg       <= 1'b0;
            copy_vld_reg <= 1'b0;
            p_vld_reg    <= 1'b0;
            upd_vld_reg  <= 1'b0;
            ovf_reg      <= 1'b0;
        end else begin
            copy_vld_reg <= cmd.copy_en;
            p_vld_reg    <= cmd.mul_en && (cmd.mul_sel != SEL_UPD);
            upd_vld_reg  <= cmd.mul_en && (cmd.mul_sel == SEL_UPD);
            if (cmd.copy_en) begin
                sw_reg <= 1'b0;
            end else if (cmd.toggle || cmd.upd_commit ||
                         (cmd.order && (acc_a_reg > acc_b_reg))) begin
                sw_reg <= ~sw_reg;
            end
            if (cmd.ovf_clr) begin
                ovf_reg <= 1'b0;
            end else if ((p_vld_reg && (acc_a_ovf || acc_b_ovf)) || (upd_vld_reg && v_bad)) begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        copy_sel_reg <= cmd.rd_sel;
        copy_idx_reg <= cmd_idx;
        if (copy_vld_reg) begin
            if (copy_sel_reg) begin
                vec1_reg[copy_idx_reg] <= ram_rdata;
            end else begin
                vec0_reg[copy_idx_reg] <= ram_rdata;
            end
        end
        // new b0 lands in the slot of the old b1, the role swap follows
        if (upd_vld_reg) begin
            if (sw_reg) begin
                vec0_reg[upd_idx_reg] <= v_sum[CB-1:0];
            end else begin
                vec1_reg[upd_idx_reg] <= v_sum[CB-1:0];
            end
        end

        p_sel_reg  <= cmd.mul_sel;
        prod_a_reg <= w0 * ((cmd.mul_sel == SEL_D) ? w1 : w0);
        prod_b_reg <= w1 * w1;
        if (cmd.acc_clr) begin
            acc_a_reg <= '0;
            acc_b_reg <= '0;
        end else if (p_vld_reg) begin
            acc_a_reg <= acc_a_next;
            if (p_sel_reg == SEL_NN) begin
                acc_b_reg <= acc_b_next;
            end
        end

        if (cmd.order) begin
            if (acc_a_reg > acc_b_reg) begin
                n0_reg <= acc_b_reg;
                n1_reg <= acc_a_reg;
            end else begin
                n0_reg <= acc_a_reg;
                n1_reg <= acc_b_reg;
            end
        end else if (cmd.upd_commit) begin
            n1_reg <= n0_reg;
        end else if (cmd.vv_latch) begin
            n0_reg <= acc_a_reg;
        end

        // |q| = round half away from zero of |d| / n0 as (2|d| + n0) / (2 n0)
        if (cmd.div_init) begin
            rem_reg   <= '0;
            quo_reg   <= (d_mag << 1) + DIV_W'(n0_reg);
            den_reg   <= DIV_W'(n0_reg) << 1;
            d_pos_reg <= acc_a_reg > 0;
        end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end

        upd_idx_reg <= cmd_idx;
        upd_w1_reg  <= w1;
        upd_p_reg   <= q_val * w0;

        if (cmd.out_load) begin
            if (cmd.out_zero) begin
                m_out_value <= '0;
            end else begin
                m_out_value <= cmd.rd_sel ? w1 : w0;
            end
        end
    end

endmodule

// ===== rtl/lgbr_ctrl.sv =====
// lgbr_ctrl: sequencing state machine, dimension register, load counting and
// result beat control. depends on lgbr_pkg.
`timescale 1ns / 1ps
module lgbr_ctrl
    import lgbr_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DIM_W-1:0]    cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [IDX_IN_W-1:0] s_component_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_out_vector,
    output logic [IDX_IN_W-1:0] m_out_index,
    output logic                m_end_of_run,
    output logic [1:0]          m_status_code,
    output cmd_t                cmd,
    output logic [IW-1:0]       cmd_idx,
    input  status_t             stat
);

    localparam int CW = $clog2(MAX_DIM + 1);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'((MAX_DIM > 15) ? 15 : MAX_DIM);

    localparam logic [4:0] S_LOAD   = 5'd0;
    localparam logic [4:0] S_COPY   = 5'd1;
    localparam logic [4:0] S_COPY_W = 5'd2;
    localparam logic [4:0] S_NN     = 5'd3;
    localparam logic [4:0] S_NN_W   = 5'd4;
    localparam logic [4:0] S_NN_CHK = 5'd5;
    localparam logic [4:0] S_D      = 5'd6;
    localparam logic [4:0] S_D_W    = 5'd7;
    localparam logic [4:0] S_D_CHK  = 5'd8;
    localparam logic [4:0] S_DIV    = 5'd9;
    localparam logic [4:0] S_UPD    = 5'd10;
    localparam logic [4:0] S_UPD_W  = 5'd11;
    localparam logic [4:0] S_UPD_CHK = 5'd12;
    localparam logic [4:0] S_VV     = 5'd13;
    localparam logic [4:0] S_VV_W   = 5'd14;
    localparam logic [4:0] S_VV_CHK = 5'd15;
    localparam logic [4:0] S_EMIT   = 5'd16;

    logic [4:0]        state_reg, state_next;
    logic [DIM_W-1:0]  dim_reg;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              vsel_reg, vsel_next;
    logic [CW:0]       cnt_reg, cnt_next;
    logic [DIVC_W-1:0] divc_reg, divc_next;
    logic [1:0]        status_reg, status_next;
    logic              m_valid_reg_q;
    logic              m_valid_next;
    logic              out_vector_next, end_next;
    logic [IDX_IN_W-1:0] out_index_next;

    logic [5:0]    dim6;
    logic [CW-1:0] dim_eff;
    logic [IW-1:0] dim_last;
    logic          in_dim, last;

    // out of range dimensions clamp to 1 .. MAX_DIM
    assign dim6     = 6'(dim_reg);
    assign dim_eff  = (dim6 == 6'd0) ? CW'(1) :
                      (dim6 > 6'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(dim6);
    assign dim_last = IW'(dim_eff - CW'(1));
    assign in_dim   = 6'(s_component_index) < 6'(dim_eff);
    assign last     = (idx_reg == dim_last);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_LOAD);
    assign m_valid   = m_valid_reg_q;
    assign cmd_idx   = idx_reg;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        vsel_next       = vsel_reg;
        cnt_next        = cnt_reg;
        divc_next       = divc_reg;
        status_next     = status_reg;
        m_valid_next    = m_valid_reg_q && !m_ready;
        out_vector_next = m_out_vector;
        out_index_next  = m_out_index;
        end_next        = m_end_of_run;
        cmd             = '0;
        cmd.rd_sel      = vsel_reg;

        case (state_reg)
            S_LOAD: begin
                if (s_valid && in_dim) begin
                    cmd.wr_en = 1'b1;
                    if ((CW+1)'(cnt_reg + 1'b1) >= {dim_eff, 1'b0}) begin
                        cnt_next   = '0;
                        idx_next   = '0;
                        vsel_next  = 1'b0;
                        state_next = S_COPY;
                    end else begin
                        cnt_next = (CW+1)'(cnt_reg + 1'b1);
                    end
                end
            end
            S_COPY: begin
                cmd.copy_en = 1'b1;
                status_next = ST_OK;
                if (last) begin
                    idx_next  = '0;
                    vsel_next = 1'b1;
                    if (vsel_reg) begin
                        vsel_next  = 1'b0;
                        state_next = S_COPY_W;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_COPY_W: begin
                cmd.acc_clr = 1'b1;
                cmd.ovf_clr = 1'b1;
                state_next  = S_NN;
            end
            S_NN, S_D, S_UPD, S_VV: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = (state_reg == S_NN) ? SEL_NN :
                              (state_reg == S_D)  ? SEL_D  :
                              (state_reg == S_UPD) ? SEL_UPD : SEL_VV;
                if (last) begin
                    idx_next   = '0;
                    state_next = state_reg + 5'd1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_NN_W, S_D_W, S_UPD_W, S_VV_W: begin
                state_next = state_reg + 5'd1;
            end
            S_NN_CHK: begin
                if (stat.ovf) begin
                    status_next = ST_OVF;
                    state_next  = S_EMIT;
                end else begin
                    cmd.order   = 1'b1;
                    cmd.acc_clr = 1'b1;
                    state_next  = S_D;
                end
            end
            S_D_CHK: begin
                if (stat.ovf) begin
                    status_next = ST_OVF;
                    state_next  = S_EMIT;
                end else if (stat.n0_zero) begin
                    status_next = ST_ZERO;
                    state_next  = S_EMIT;
                end else begin
                    cmd.div_init = 1'b1;
                    divc_next    = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                divc_next    = divc_reg + 1'b1;
                if (divc_reg == DIVC_W'(DIV_W - 1)) begin
                    state_next = S_UPD;
                end
            end
            S_UPD_CHK: begin
                if (stat.ovf || stat.qbig) begin
                    status_next = ST_OVF;
                    state_next  = S_EMIT;
                end else begin
                    cmd.upd_commit = 1'b1;
                    cmd.acc_clr    = 1'b1;
                    state_next     = S_VV;
                end
            end
            S_VV_CHK: begin
                if (stat.ovf) begin
                    status_next = ST_OVF;
                    state_next  = S_EMIT;
                end else if (stat.vv_lt) begin
                    cmd.vv_latch = 1'b1;
                    cmd.acc_clr  = 1'b1;
                    state_next   = S_D;
                end else begin
                    // final swap leaves the shorter vector first
                    cmd.toggle = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg_q || m_ready) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_zero    = (status_reg != ST_OK);
                    m_valid_next    = 1'b1;
                    out_vector_next = vsel_reg;
                    out_index_next  = IDX_IN_W'(idx_reg);
                    end_next        = vsel_reg && last;
                    if (last) begin
                        idx_next  = '0;
                        vsel_next = 1'b1;
                        if (vsel_reg) begin
                            vsel_next  = 1'b0;
                            state_next = S_LOAD;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            dim_reg       <= DIM_RESET;
            idx_reg       <= '0;
            vsel_reg      <= 1'b0;
            cnt_reg       <= '0;
            divc_reg      <= '0;
            status_reg    <= ST_OK;
            m_valid_reg_q <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            vsel_reg      <= vsel_next;
            cnt_reg       <= cnt_next;
            divc_reg      <= divc_next;
            status_reg    <= status_next;
            m_valid_reg_q <= m_valid_next;
            if (cfg_valid) begin
                dim_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_out_vector  <= out_vector_next;
        m_out_index   <= out_index_next;
        m_end_of_run  <= end_next;
        if (cmd.out_load) begin
            m_status_code <= status_reg;
        end
    end

endmodule

// ===== rtl/lagrange_gauss_basis_reduction.sv =====
// lagrange_gauss_basis_reduction: top level, joins the controller and datapath.
// depends on lgbr_pkg, lgbr_ctrl, lgbr_datapath, lgbr_ram.
//
// usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) sets the number of components per
//   vector; write it only while idle. cfg_ready is always high.
//   s channel takes one component per beat (vector select, index, value).
//   components with index at or above the dimension are dropped. once 2*dim
//   components have been counted, a reduction run starts and s_ready drops.
//   m channel then delivers 2*dim beats: reduced vector 0 (shorter) then 1,
//   end_of_run on the last beat, status on every beat; on error values are 0.
// run sequence:
//   loading accepts one beat per cycle. a run copies the basis store, computes
//   the initial norms, then repeats reduction steps, each dominated by the
//   bit-serial rounding divider, then emits the result beats.
// reset: synchronous, active low; clears the counters, drops m_valid and sets
//   the dimension to its maximum. the basis store is not cleared.
// a stalled receiver holds the current result beat and freezes the run.
`timescale 1ns / 1ps
module lagrange_gauss_basis_reduction
    import lgbr_pkg::*;
#(
    parameter int MAX_DIM        = DEF_MAX_DIM,
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [DIM_W-1:0]                 cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_vector_select,
    input  logic [IDX_IN_W-1:0]              s_component_index,
    input  logic signed [COMPONENT_BITS-1:0] s_component_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_out_vector,
    output logic [IDX_IN_W-1:0]              m_out_index,
    output logic signed [COMPONENT_BITS-1:0] m_out_value,
    output logic                             m_end_of_run,
    output logic [1:0]                       m_status_code
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    cmd_t          cmd;
    status_t       stat;
    logic [IW-1:0] cmd_idx;

    lgbr_ctrl #(
        .MAX_DIM(MAX_DIM),
        .IW     (IW)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_component_index(s_component_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_vector     (m_out_vector),
        .m_out_index      (m_out_index),
        .m_end_of_run     (m_end_of_run),
        .m_status_code    (m_status_code),
        .cmd              (cmd),
        .cmd_idx          (cmd_idx),
        .stat             (stat)
    );

    lgbr_datapath #(
        .MAX_DIM       (MAX_DIM),
        .COMPONENT_BITS(COMPONENT_BITS),
        .IW            (IW)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cmd_idx          (cmd_idx),
        .stat             (stat),
        .s_vector_select  (s_vector_select),
        .s_component_index(s_component_index),
        .s_component_value(s_component_value),
        .m_out_value      (m_out_value)
    );

endmodule

// ===== rtl/lgbr_checker.sv =====
// lgbr_props: port level assertions for the basis reduction top level,
// attached by bind. depends on lgbr_pkg.
`timescale 1ns / 1ps
module lgbr_props
    import lgbr_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_out_vector,
    input logic signed [COMPONENT_BITS-1:0] m_out_value,
    input logic                             m_end_of_run,
    input logic [1:0]                       m_status_code
);

    // a stalled beat stays up
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // last beat of a run belongs to the second vector
    a_end_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_run |-> m_out_vector)
        else $error("end of run on first vector");

    // error runs carry zero values
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status_code != ST_OK) |-> (m_out_value == '0))
        else $error("nonzero value on error beat");

    // input is not taken while results are being emitted back to back
    a_no_load_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_end_of_run && m_ready |=> !s_ready || m_valid)
        else $error("load reopened mid run");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lagrange_gauss_basis_reduction lgbr_props #(
    .COMPONENT_BITS(COMPONENT_BITS)
) u_lgbr_props (.*);
